### src/lfa_pkg.sv
// ----------------------------------------------------------------------------
// lfa_pkg
// Shared widths, constants and types of the leaky frame averager.
// ----------------------------------------------------------------------------
package lfa_pkg;

	localparam int SAMPLE_W       = 32;
	localparam int ELEM_W         = 12;
	localparam int STEPS_W        = 16;
	localparam int GAIN_W         = 25;
	localparam int MS_W           = 63;
	localparam int GAIN_FRAC_BITS = 24;
	localparam int ELEMENTS_DEF   = 4096;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = GAIN_W;

	// shared multiplier operands and accumulator
	localparam int OPA_W  = SAMPLE_W + 1;
	localparam int OPB_W  = GAIN_W + 1;
	localparam int PROD_W = OPA_W + OPB_W;
	localparam int ACC_W  = GAIN_FRAC_BITS + 64;

	localparam logic [GAIN_W-1:0] GAIN_ONE  = GAIN_W'(1) << GAIN_FRAC_BITS;
	localparam logic [GAIN_W-1:0] GAIN_HALF = GAIN_W'(1) << (GAIN_FRAC_BITS - 1);

	// reset gain is 1e-5 in Q1.24, rounded
	localparam int GAIN_RESET_DIV = 100000;
	localparam int GAIN_RESET_I   =
		((1 << GAIN_FRAC_BITS) + GAIN_RESET_DIV / 2) / GAIN_RESET_DIV;
	localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(GAIN_RESET_I);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GAIN   = 1'b0,
		CFG_SQUARE = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		SH_0  = 2'd0,
		SH_16 = 2'd1,
		SH_32 = 2'd2
	} mac_shift_t;

	typedef struct packed {
		logic       valid;
		logic       clear;
		logic       half;
		mac_shift_t shift;
	} mac_op_t;

	function automatic int idx_width(input int depth);
		idx_width = (depth > 1) ? $clog2(depth) : 1;
	endfunction

endpackage

### src/lfa_in_if.sv
// ----------------------------------------------------------------------------
// lfa_in_if
// Element request channel: one frame element per request.
// ----------------------------------------------------------------------------
interface lfa_in_if import lfa_pkg::*; ();

	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample;
	logic [ELEM_W-1:0]          element;
	logic [STEPS_W-1:0]         steps;
	logic                       restart;
	logic                       last_in_frame;

	modport source (
		output valid, sample, element, steps, restart, last_in_frame,
		input  ready
	);

	modport sink (
		input  valid, sample, element, steps, restart, last_in_frame,
		output ready
	);

endinterface

### src/lfa_out_if.sv
// ----------------------------------------------------------------------------
// lfa_out_if
// Result request channel: updated averages of one element.
// ----------------------------------------------------------------------------
interface lfa_out_if import lfa_pkg::*; ();

	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] average;
	logic [MS_W-1:0]            mean_square;
	logic [ELEM_W-1:0]          out_element;
	logic                       out_last;

	modport source (
		output valid, average, mean_square, out_element, out_last,
		input  ready
	);

	modport sink (
		input  valid, average, mean_square, out_element, out_last,
		output ready
	);

endinterface

### src/lfa_mac.sv
// ----------------------------------------------------------------------------
// lfa_mac
// Shared signed multiply-accumulate unit: registered product, then a
// shifted accumulate with optional clear and rounding offset.
// ----------------------------------------------------------------------------
module lfa_mac import lfa_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  mac_op_t                 op,
	input  logic signed [OPA_W-1:0] opa,
	input  logic signed [OPB_W-1:0] opb,
	output logic [ACC_W-1:0]        acc
);

	logic signed [PROD_W-1:0] prod_s1;
	mac_op_t                  op_s1;
	logic [ACC_W-1:0]         acc_q;
	logic signed [ACC_W-1:0]  prod_ext;
	logic [ACC_W-1:0]         addend;
	logic [ACC_W-1:0]         base;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1 <= '0;
		end else begin
			op_s1 <= op;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= PROD_W'(opa) * PROD_W'(opb);
	end

	assign prod_ext = ACC_W'(prod_s1);

	always_comb begin
		case (op_s1.shift)
			SH_0:    addend = prod_ext;
			SH_16:   addend = prod_ext << 16;
			SH_32:   addend = prod_ext << 32;
			default: addend = prod_ext;
		endcase
		if (op_s1.clear) begin
			base = op_s1.half ? ACC_W'(GAIN_HALF) : '0;
		end else begin
			base = acc_q;
		end
	end

	always_ff @(posedge clk) begin
		if (op_s1.valid) begin
			acc_q <= base + addend;
		end
	end

	assign acc = acc_q;

endmodule

### src/lfa_store.sv
// ----------------------------------------------------------------------------
// lfa_store
// Per-element history: average store and square store, one read and one
// write port each, registered read data.
// ----------------------------------------------------------------------------
module lfa_store import lfa_pkg::*; #(
	parameter int ELEMENTS = ELEMENTS_DEF,
	parameter int IDX_W    = idx_width(ELEMENTS)
) (
	input  logic                       clk,
	input  logic                       rd_en,
	input  logic [IDX_W-1:0]           addr,
	input  logic                       wr_avg,
	input  logic                       wr_sq,
	input  logic signed [SAMPLE_W-1:0] avg_wdata,
	input  logic [MS_W-1:0]            sq_wdata,
	output logic signed [SAMPLE_W-1:0] avg_rdata,
	output logic [MS_W-1:0]            sq_rdata
);

	logic signed [SAMPLE_W-1:0] avg_mem [ELEMENTS];
	logic [MS_W-1:0]            sq_mem  [ELEMENTS];

	always_ff @(posedge clk) begin
		if (wr_avg) begin
			avg_mem[addr] <= avg_wdata;
		end
		if (rd_en) begin
			avg_rdata <= avg_mem[addr];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_sq) begin
			sq_mem[addr] <= sq_wdata;
		end
		if (rd_en) begin
			sq_rdata <= sq_mem[addr];
		end
	end

endmodule

### src/leaky_frame_averager.sv
// ----------------------------------------------------------------------------
// leaky_frame_averager
// Per-element exponential moving average of a streamed frame, with an
// optional average of squares. On the first element of a frame with history,
// decay^steps comes from square-and-multiply; all products share one multiplier.
// ----------------------------------------------------------------------------
//  channel   | dir | handshake     | payload
//  ----------+-----+---------------+------------------------------------------
//  samples   | in  | valid/ready   | sample, element, steps, restart, last
//  results   | out | valid/ready   | average, mean_square, out_element, out_last
//  cfg       | in  | cfg_we        | cfg_index, cfg_data
//
//  Each element passes through the shared multiply-accumulate unit, more
//  often with squares enabled. The first element of a frame with history
//  and no restart raises decay to the power steps, one round per steps-bit.
//  ELEMENTS below 4096 adds an index reduction. A stalled result holds in
//  the output register; the next request is taken meanwhile and its update
//  waits for that register. Stores need no clearing after reset.
// ----------------------------------------------------------------------------
module leaky_frame_averager import lfa_pkg::*; #(
	parameter int ELEMENTS = ELEMENTS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	lfa_in_if.sink                samples,
	lfa_out_if.source             results
);

	localparam int IDX_W    = idx_width(ELEMENTS);
	localparam bit NEED_MOD = (ELEMENTS < (1 << ELEM_W));
	localparam int MOD_W    = 2 * ELEM_W;
	localparam int CNT_W    = 4;

	localparam logic [CNT_W-1:0] MOD_FIRST = CNT_W'(ELEM_W - 1);
	localparam logic [CNT_W-1:0] POW_LAST  = CNT_W'(STEPS_W - 1);

	// arithmetic steps of one element
	localparam logic [CNT_W-1:0] C_AVG_OLD = 4'd0;
	localparam logic [CNT_W-1:0] C_AVG_NEW = 4'd1;
	localparam logic [CNT_W-1:0] C_SQ_LO   = 4'd2;
	localparam logic [CNT_W-1:0] C_SQ_HI   = 4'd3;
	localparam logic [CNT_W-1:0] C_MS_OLDL = 4'd4;
	localparam logic [CNT_W-1:0] C_MS_OLDH = 4'd5;
	localparam logic [CNT_W-1:0] C_MS_NEWL = 4'd6;
	localparam logic [CNT_W-1:0] C_MS_NEWH = 4'd7;
	localparam logic [CNT_W-1:0] C_MS_DONE = 4'd9;

	typedef enum logic [8:0] {
		S_IDLE   = 9'b000000001,
		S_MOD    = 9'b000000010,
		S_POW_R  = 9'b000000100,
		S_POW_B  = 9'b000001000,
		S_POW_CR = 9'b000010000,
		S_POW_CB = 9'b000100000,
		S_READ   = 9'b001000000,
		S_CALC   = 9'b010000000,
		S_DONE   = 9'b100000000
	} state_t;

	state_t                     state_q;
	logic [CNT_W-1:0]           cnt_q;
	logic [GAIN_W-1:0]          gain_q;
	logic                       sqen_q;
	logic                       has_hist_q;
	logic                       in_frame_q;
	logic                       pow_q;
	logic [GAIN_W-1:0]          decay_q;
	logic [GAIN_W-1:0]          fgain_q;
	logic                       out_valid_q;

	logic signed [SAMPLE_W-1:0] x_q;
	logic [ELEM_W-1:0]          elem_q;
	logic [ELEM_W-1:0]          rem_q;
	logic [STEPS_W-1:0]         steps_q;
	logic                       last_q;
	logic [GAIN_W-1:0]          r_q;
	logic [GAIN_W-1:0]          b_q;
	logic [63:0]                sq_q;
	logic signed [SAMPLE_W-1:0] avg_res_q;
	logic [MS_W-1:0]            ms_res_q;
	logic signed [SAMPLE_W-1:0] avg_out_q;
	logic [MS_W-1:0]            ms_out_q;
	logic [ELEM_W-1:0]          elem_out_q;
	logic                       last_out_q;

	logic                       accept;
	logic                       first;
	logic                       load;
	logic                       mod_sub;
	logic [MOD_W-1:0]           mod_div;
	logic [GAIN_W-1:0]          gain_sat;
	logic [SAMPLE_W-1:0]        mag;
	logic                       hist_zero;
	logic signed [SAMPLE_W-1:0] a_old;
	logic [MS_W-1:0]            v_old;
	logic signed [SAMPLE_W-1:0] avg_sat;
	logic                       can_load;

	mac_op_t                    op;
	logic signed [OPA_W-1:0]    opa;
	logic signed [OPB_W-1:0]    opb;
	logic [ACC_W-1:0]           acc;
	logic signed [SAMPLE_W-1:0] avg_rdata;
	logic [MS_W-1:0]            sq_rdata;
	logic [IDX_W-1:0]           addr;

	assign samples.ready = (state_q == S_IDLE);
	assign accept        = samples.valid && samples.ready;
	assign first         = !in_frame_q;
	assign load          = !has_hist_q || samples.restart;
	assign gain_sat      = (gain_q > GAIN_ONE) ? GAIN_ONE : gain_q;

	assign mod_div = MOD_W'(ELEMENTS) << cnt_q;
	assign mod_sub = (MOD_W'(rem_q) >= mod_div);

	assign mag       = x_q[SAMPLE_W-1] ? (~x_q + 1'b1) : x_q;
	assign hist_zero = (decay_q == '0);
	assign a_old     = hist_zero ? '0 : avg_rdata;
	assign v_old     = hist_zero ? '0 : sq_rdata;
	assign addr      = IDX_W'(rem_q);
	assign can_load  = !out_valid_q || results.ready;

	// shifted sum with rounding offset, saturated to the sample range
	always_comb begin
		if (acc[GAIN_FRAC_BITS+33:GAIN_FRAC_BITS+31] == 3'b000 ||
		    acc[GAIN_FRAC_BITS+33:GAIN_FRAC_BITS+31] == 3'b111) begin
			avg_sat = acc[GAIN_FRAC_BITS +: SAMPLE_W];
		end else begin
			avg_sat = acc[GAIN_FRAC_BITS+33] ? {1'b1, {(SAMPLE_W-1){1'b0}}}
			                                 : {1'b0, {(SAMPLE_W-1){1'b1}}};
		end
	end

	always_comb begin
		op  = '{valid: 1'b0, clear: 1'b0, half: 1'b0, shift: SH_0};
		opa = '0;
		opb = '0;
		case (state_q)
			S_POW_R: begin
				op  = '{valid: 1'b1, clear: 1'b1, half: 1'b1, shift: SH_0};
				opa = OPA_W'(r_q);
				opb = OPB_W'(b_q);
			end
			S_POW_B: begin
				op  = '{valid: 1'b1, clear: 1'b1, half: 1'b1, shift: SH_0};
				opa = OPA_W'(b_q);
				opb = OPB_W'(b_q);
			end
			S_CALC: begin
				case (cnt_q)
					C_AVG_OLD: begin
						op  = '{valid: 1'b1, clear: 1'b1, half: 1'b1, shift: SH_0};
						opa = OPA_W'(a_old);
						opb = OPB_W'(decay_q);
					end
					C_AVG_NEW: begin
						op  = '{valid: 1'b1, clear: 1'b0, half: 1'b0, shift: SH_0};
						opa = OPA_W'(x_q);
						opb = OPB_W'(fgain_q);
					end
					C_SQ_LO: begin
						op  = '{valid: 1'b1, clear: 1'b1, half: 1'b0, shift: SH_0};
						opa = OPA_W'(mag);
						opb = OPB_W'(mag[15:0]);
					end
					C_SQ_HI: begin
						op  = '{valid: 1'b1, clear: 1'b0, half: 1'b0, shift: SH_16};
						opa = OPA_W'(mag);
						opb = OPB_W'(mag[31:16]);
					end
					C_MS_OLDL: begin
						op  = '{valid: 1'b1, clear: 1'b1, half: 1'b1, shift: SH_0};
						opa = OPA_W'(v_old[31:0]);
						opb = OPB_W'(decay_q);
					end
					C_MS_OLDH: begin
						op  = '{valid: 1'b1, clear: 1'b0, half: 1'b0, shift: SH_32};
						opa = OPA_W'(v_old[MS_W-1:32]);
						opb = OPB_W'(decay_q);
					end
					C_MS_NEWL: begin
						op  = '{valid: 1'b1, clear: 1'b0, half: 1'b0, shift: SH_0};
						opa = OPA_W'(sq_q[31:0]);
						opb = OPB_W'(fgain_q);
					end
					C_MS_NEWH: begin
						op  = '{valid: 1'b1, clear: 1'b0, half: 1'b0, shift: SH_32};
						opa = OPA_W'(sq_q[63:32]);
						opb = OPB_W'(fgain_q);
					end
					default: begin
						op = '{valid: 1'b0, clear: 1'b0, half: 1'b0, shift: SH_0};
					end
				endcase
			end
			default: begin
				op = '{valid: 1'b0, clear: 1'b0, half: 1'b0, shift: SH_0};
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			gain_q      <= GAIN_RESET;
			sqen_q      <= 1'b0;
			has_hist_q  <= 1'b0;
			in_frame_q  <= 1'b0;
			pow_q       <= 1'b0;
			decay_q     <= '0;
			fgain_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					CFG_GAIN:   gain_q <= cfg_data;
					CFG_SQUARE: sqen_q <= cfg_data[0];
					default:    ;
				endcase
			end

			if (state_q == S_DONE && can_load) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						pow_q <= first && !load;
						if (first) begin
							has_hist_q <= 1'b1;
							if (load) begin
								decay_q <= '0;
								fgain_q <= GAIN_ONE;
							end
						end
						in_frame_q <= !samples.last_in_frame;
						if (NEED_MOD) begin
							cnt_q   <= MOD_FIRST;
							state_q <= S_MOD;
						end else if (first && !load) begin
							cnt_q   <= '0;
							state_q <= S_POW_R;
						end else begin
							state_q <= S_READ;
						end
					end
				end
				S_MOD: begin
					if (cnt_q == '0) begin
						state_q <= pow_q ? S_POW_R : S_READ;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				S_POW_R:  state_q <= S_POW_B;
				S_POW_B:  state_q <= S_POW_CR;
				S_POW_CR: state_q <= S_POW_CB;
				S_POW_CB: begin
					if (cnt_q == POW_LAST) begin
						decay_q <= r_q;
						fgain_q <= GAIN_ONE - r_q;
						state_q <= S_READ;
					end else begin
						cnt_q   <= cnt_q + 1'b1;
						state_q <= S_POW_R;
					end
				end
				S_READ: begin
					cnt_q   <= C_AVG_OLD;
					state_q <= S_CALC;
				end
				S_CALC: begin
					if ((cnt_q == C_SQ_HI && !sqen_q) || cnt_q == C_MS_DONE) begin
						state_q <= S_DONE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_DONE: begin
					if (can_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					x_q     <= samples.sample;
					elem_q  <= samples.element;
					rem_q   <= samples.element;
					steps_q <= samples.steps;
					last_q  <= samples.last_in_frame;
					r_q     <= GAIN_ONE;
					b_q     <= GAIN_ONE - gain_sat;
				end
			end
			S_MOD: begin
				if (mod_sub) begin
					rem_q <= rem_q - ELEM_W'(mod_div);
				end
			end
			S_POW_CR: begin
				if (steps_q[cnt_q]) begin
					r_q <= acc[GAIN_FRAC_BITS +: GAIN_W];
				end
			end
			S_POW_CB: begin
				b_q <= acc[GAIN_FRAC_BITS +: GAIN_W];
			end
			S_CALC: begin
				if (cnt_q == C_SQ_HI) begin
					avg_res_q <= avg_sat;
					if (!sqen_q) begin
						ms_res_q <= '0;
					end
				end
				if (cnt_q == C_MS_OLDH) begin
					sq_q <= acc[63:0];
				end
				if (cnt_q == C_MS_DONE) begin
					ms_res_q <= acc[GAIN_FRAC_BITS +: MS_W];
				end
			end
			S_DONE: begin
				if (can_load) begin
					avg_out_q  <= avg_res_q;
					ms_out_q   <= ms_res_q;
					elem_out_q <= elem_q;
					last_out_q <= last_q;
				end
			end
			default: ;
		endcase
	end

	lfa_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (op),
		.opa    (opa),
		.opb    (opb),
		.acc    (acc)
	);

	lfa_store #(
		.ELEMENTS (ELEMENTS),
		.IDX_W    (IDX_W)
	) u_store (
		.clk       (clk),
		.rd_en     (state_q == S_READ),
		.addr      (addr),
		.wr_avg    (state_q == S_DONE && can_load),
		.wr_sq     (state_q == S_DONE && can_load && sqen_q),
		.avg_wdata (avg_res_q),
		.sq_wdata  (ms_res_q),
		.avg_rdata (avg_rdata),
		.sq_rdata  (sq_rdata)
	);

	assign results.valid       = out_valid_q;
	assign results.average     = avg_out_q;
	assign results.mean_square = ms_out_q;
	assign results.out_element = elem_out_q;
	assign results.out_last    = last_out_q;

endmodule

### bench/lfa_result_check.sv
// ----------------------------------------------------------------------------
// lfa_result_check
// Watches the sample and result channels and the register port. It keeps its
// own per-element averages, predicts every result and compares the results
// in order, field by field.
// ----------------------------------------------------------------------------
module lfa_result_check import lfa_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	lfa_in_if                     samples,
	lfa_out_if                    results,
	output int                    results_due,
	output int                    mismatches
);

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [SAMPLE_W-1:0] average;
		logic [MS_W-1:0]     mean_square;
		logic [ELEM_W-1:0]   element;
		logic                last;
	} element_result_t;

	element_result_t   due_q [$];
	int                avg_mem [ELEMENTS_DEF];
	logic [MS_W-1:0]   sq_mem [ELEMENTS_DEF];
	logic [GAIN_W-1:0] gain_reg;
	logic              square_on;
	logic              has_history;
	logic              in_frame;
	logic [GAIN_W-1:0] decay;
	logic [GAIN_W-1:0] fgain;

	task automatic report_mismatch(input string msg);
		mismatches++;
		$display("%0t ns mismatch: %s", $realtime, msg);
	endtask

	always @(posedge clk or negedge arst_n) begin : predict
		element_result_t   want;
		element_result_t   got;
		logic [63:0]       base;
		logic [63:0]       power;
		logic [GAIN_W-1:0] g;
		longint            acc;
		longint            avg;
		longint            mag;
		logic [63:0]       mag2;
		logic [127:0]      wide;
		logic [MS_W-1:0]   ms;
		int                slot;
		if (!arst_n) begin
			due_q.delete();
			for (int i = 0; i < ELEMENTS_DEF; i++) begin
				avg_mem[i] = 0;
				sq_mem[i]  = '0;
			end
			gain_reg    = GAIN_RESET;
			square_on   = 1'b0;
			has_history = 1'b0;
			in_frame    = 1'b0;
			decay       = '0;
			fgain       = '0;
			results_due = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_GAIN:   gain_reg  = cfg_data;
					CFG_SQUARE: square_on = cfg_data[0];
					default: ;
				endcase
			end

			if (results.valid === 1'b1 && results.ready === 1'b1) begin
				got = {results.average, results.mean_square, results.out_element,
					results.out_last};
				if (due_q.size() == 0) begin
					report_mismatch($sformatf("result for element %0d with none pending",
						got.element));
				end else begin
					want = due_q.pop_front();
					if (got.average !== want.average)
						report_mismatch($sformatf("element %0d average %h, expected %h",
							want.element, got.average, want.average));
					if (got.mean_square !== want.mean_square)
						report_mismatch($sformatf("element %0d mean_square %h, expected %h",
							want.element, got.mean_square, want.mean_square));
					if (got.element !== want.element)
						report_mismatch($sformatf("out_element %h, expected %h",
							got.element, want.element));
					if (got.last !== want.last)
						report_mismatch($sformatf("element %0d out_last %b, expected %b",
							want.element, got.last, want.last));
				end
			end

			if (samples.valid === 1'b1 && samples.ready === 1'b1) begin
				// decay^steps and its complement are latched per frame
				if (!in_frame) begin
					if (!has_history || samples.restart) begin
						decay = '0;
						fgain = GAIN_ONE;
					end else begin
						g     = (gain_reg > GAIN_ONE) ? GAIN_ONE : gain_reg;
						base  = 64'(GAIN_ONE - g);
						power = 64'(GAIN_ONE);
						for (int i = 0; i < STEPS_W; i++) begin
							if (samples.steps[i])
								power = (power * base + 64'(GAIN_HALF)) >> GAIN_FRAC_BITS;
							base = (base * base + 64'(GAIN_HALF)) >> GAIN_FRAC_BITS;
						end
						decay = power[GAIN_W-1:0];
						fgain = GAIN_ONE - decay;
					end
					has_history = 1'b1;
				end
				in_frame = !samples.last_in_frame;

				slot = int'(samples.element) % ELEMENTS_DEF;
				acc  = longint'(decay) * longint'(avg_mem[slot])
					+ longint'(fgain) * longint'(samples.sample) + longint'(GAIN_HALF);
				avg  = acc >>> GAIN_FRAC_BITS;
				if (avg > longint'(32'sh7FFF_FFFF))
					avg = longint'(32'sh7FFF_FFFF);
				if (avg < longint'(32'sh8000_0000))
					avg = longint'(32'sh8000_0000);
				avg_mem[slot] = int'(avg);

				ms = '0;
				if (square_on) begin
					mag  = (samples.sample < 0) ? -longint'(samples.sample)
						: longint'(samples.sample);
					mag2 = mag * mag;
					wide = 128'(decay) * 128'(sq_mem[slot]) + 128'(fgain) * 128'(mag2)
						+ 128'(GAIN_HALF);
					ms   = wide[GAIN_FRAC_BITS+MS_W-1:GAIN_FRAC_BITS];
					sq_mem[slot] = ms;
				end

				want.average     = avg[SAMPLE_W-1:0];
				want.mean_square = ms;
				want.element     = samples.element;
				want.last        = samples.last_in_frame;
				due_q.push_back(want);
			end
			results_due = due_q.size();
		end
	end

endmodule

### bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives frames of elements into the leaky frame averager under random
// sender bursts and receiver stalls, across several gain and square
// settings. A directed opening covers sample and index extremes, restart,
// zero and full step counts, gain above one and a mid-frame gain write;
// random frames follow. Results are checked by lfa_result_check.
// ----------------------------------------------------------------------------
module testbench import lfa_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int RANDOM_ITEMS = 1200;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    results_due;
	int                    mismatches;
	int                    cycle_count = 0;

	// stimulus bookkeeping: which entries hold an average, and a square
	bit                    written [ELEMENTS_DEF];
	bit                    sq_ok [ELEMENTS_DEF];
	int                    written_q [$];
	logic                  sq_now = 1'b0;
	int                    burst_left = 0;

	logic [10:0]           stall_pat = '1;
	int                    pat_age = 0;

	lfa_in_if  samples_if ();
	lfa_out_if results_if ();

	leaky_frame_averager dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.samples   (samples_if),
		.results   (results_if)
	);

	lfa_result_check u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.samples     (samples_if),
		.results     (results_if),
		.results_due (results_due),
		.mismatches  (mismatches)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// receiver: rotating ready pattern, reloaded now and then
	always @(negedge clk) begin
		if (pat_age == 0) begin
			pat_age   = $urandom_range(20, 120);
			stall_pat = ($urandom_range(0, 3) == 0) ? '1 : 11'($urandom);
			if (stall_pat == '0)
				stall_pat = 11'd1;
		end
		pat_age--;
		results_if.ready = stall_pat[0];
		stall_pat = {stall_pat[0], stall_pat[10:1]};
	end

	function automatic logic [STEPS_W-1:0] pick_steps();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return '1;
			2:       return STEPS_W'($urandom);
			default: return STEPS_W'($urandom_range(1, 8));
		endcase
	endfunction

	task automatic send_item(input logic [SAMPLE_W-1:0] x, input logic [ELEM_W-1:0] e,
		input logic [STEPS_W-1:0] st, input logic rs, input logic last);
		int gap;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
		end
		burst_left--;
		@(negedge clk);
		if (gap != 0) begin
			samples_if.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		samples_if.valid         = 1'b1;
		samples_if.sample        = x;
		samples_if.element       = e;
		samples_if.steps         = st;
		samples_if.restart       = rs;
		samples_if.last_in_frame = last;
		@(posedge clk);
		while (samples_if.ready !== 1'b1)
			@(posedge clk);
		if (!written[e]) begin
			written[e] = 1'b1;
			written_q.push_back(e);
		end
		if (sq_now)
			sq_ok[e] = 1'b1;
	endtask

	task automatic drain();
		@(negedge clk);
		samples_if.valid = 1'b0;
		while (results_due != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		@(negedge clk);
		cfg_we = 1'b0;
		if (idx == CFG_SQUARE)
			sq_now = val[0];
	endtask

	initial begin
		int                    phase;
		int                    phase_items;
		int                    random_items;
		int                    frame_len;
		int                    cands [$];
		bit                    fresh;
		logic [ELEM_W-1:0]     e;
		logic [SAMPLE_W-1:0]   x;
		logic [CFG_DATA_W-1:0] gain_val;

		cfg_we                   = 1'b0;
		cfg_index                = CFG_GAIN;
		cfg_data                 = '0;
		samples_if.valid         = 1'b0;
		samples_if.sample        = '0;
		samples_if.element       = '0;
		samples_if.steps         = '0;
		samples_if.restart       = 1'b0;
		samples_if.last_in_frame = 1'b0;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// first frame after reset loads the samples directly
		send_item(32'h7FFF_FFFF, 12'h000, 16'hFFFF, 1'b0, 1'b0);
		send_item(32'h8000_0000, 12'hFFF, 16'h0000, 1'b1, 1'b0);
		send_item(32'h0000_0000, 12'hAAA, 16'h0001, 1'b0, 1'b0);
		send_item(32'hFFFF_FFFF, 12'h555, 16'h0001, 1'b1, 1'b1);
		// reset gain, full step count; later fields ignored
		send_item(32'h8000_0000, 12'h000, 16'hFFFF, 1'b0, 1'b0);
		send_item(32'h7FFF_FFFF, 12'hFFF, 16'h0000, 1'b1, 1'b0);
		send_item(32'h0001_0000, 12'hAAA, 16'h1234, 1'b1, 1'b0);
		send_item(32'hFFFF_0000, 12'h555, 16'h0000, 1'b0, 1'b1);
		drain();
		write_reg(CFG_SQUARE, 25'd1);
		write_reg(CFG_GAIN, GAIN_ONE >> 3);
		send_item(32'h8000_0000, 12'h000, 16'd7, 1'b1, 1'b0);
		send_item(32'h7FFF_FFFF, 12'hFFF, 16'd7, 1'b0, 1'b1);
		// zero steps hold the averages
		send_item(32'h1234_5678, 12'h000, 16'd0, 1'b0, 1'b0);
		send_item(32'h0000_0001, 12'hFFF, 16'd0, 1'b0, 1'b1);
		// gain written mid-frame applies from the next frame
		send_item(32'h0020_0000, 12'h000, 16'd3, 1'b0, 1'b0);
		drain();
		write_reg(CFG_GAIN, 25'h1FF_FFFF);
		send_item(32'hFFE0_0000, 12'hFFF, 16'd3, 1'b0, 1'b1);
		send_item(32'h0123_4567, 12'h000, 16'd1, 1'b0, 1'b1);
		drain();
		write_reg(CFG_GAIN, '0);
		send_item(32'h7654_3210, 12'hFFF, 16'd5, 1'b0, 1'b1);

		phase        = 0;
		random_items = 0;
		while (random_items < RANDOM_ITEMS) begin
			drain();
			case (phase % 8)
				0:       gain_val = '0;
				1:       gain_val = GAIN_ONE;
				2:       gain_val = 25'h1FF_FFFF;
				3:       gain_val = GAIN_RESET;
				4:       gain_val = 25'd1;
				5:       gain_val = GAIN_ONE >> 3;
				6:       gain_val = GAIN_ONE >> 8;
				default: gain_val = 25'($urandom_range(0, 1 << GAIN_FRAC_BITS));
			endcase
			write_reg(CFG_GAIN, gain_val);
			write_reg(CFG_SQUARE, 25'(phase % 3 != 0));

			phase_items = 0;
			while (phase_items < 150) begin
				frame_len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40)
					: $urandom_range(1, 8);
				// history frames only touch entries that hold every store in use
				cands.delete();
				foreach (written_q[k])
					if (!sq_now || sq_ok[written_q[k]])
						cands.push_back(written_q[k]);
				fresh = (cands.size() == 0) || ($urandom_range(0, 7) == 0);
				for (int n = 0; n < frame_len; n++) begin
					if (!fresh)
						e = ELEM_W'(cands[$urandom_range(0, cands.size() - 1)]);
					else if ($urandom_range(0, 3) == 0)
						e = ELEM_W'($urandom);
					else
						e = ELEM_W'(written_q[$urandom_range(0, written_q.size() - 1)]);
					case ($urandom_range(0, 9))
						0:       x = 32'h8000_0000;
						1:       x = 32'h7FFF_FFFF;
						2:       x = 32'($signed(16'($urandom)));
						3:       x = 32'($signed(24'($urandom)));
						default: x = $urandom;
					endcase
					send_item(x, e, pick_steps(),
						(n == 0) ? fresh : 1'($urandom_range(0, 1)), n == frame_len - 1);
					phase_items++;
					random_items++;
				end
			end
			phase++;
		end

		drain();
		repeat (100) @(posedge clk);
		if (mismatches == 0 && results_due == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

### files.f
src/lfa_pkg.sv
src/lfa_in_if.sv
src/lfa_out_if.sv
src/lfa_mac.sv
src/lfa_store.sv
src/leaky_frame_averager.sv
bench/lfa_result_check.sv
bench/testbench.sv
